[sv/pidl_pkg.sv]
// shared types, constants and microcode table of the pid controller
// used by pidl_datapath and pid_leaky_integrator_controller; depends on nothing
`default_nettype none

package pidl_pkg;

  // sample and state widths
  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int INTEG_W    = 32;
  localparam int INTEG_FRAC = 8;
  localparam int BAND_W     = 15;
  localparam int LIMIT_W    = 23;

  // leak factor 65470 / 65536
  localparam int LEAK_NUM   = 65470;
  localparam int LEAK_SHIFT = 16;

  // shared multiplier and accumulator
  localparam int MUL_A_W   = INTEG_W + 1;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 48;
  localparam int SUM_SHIFT = GAIN_FRAC + INTEG_FRAC;

  // configuration port
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LIMITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMITS  = 3'd7;

  // multiplier operand pairs
  localparam logic [1:0] MUL_LEAK = 2'd0;
  localparam logic [1:0] MUL_KP   = 2'd1;
  localparam logic [1:0] MUL_KD   = 2'd2;
  localparam logic [1:0] MUL_KI   = 2'd3;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_ADD   = 2'd2;
  localparam logic [1:0] ACC_SHADD = 2'd3;

  // sequencing: go on, or hold until the output slot is free and end
  localparam logic JMP_NEXT = 1'b0;
  localparam logic JMP_END  = 1'b1;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

  typedef struct packed {
    logic [1:0] mul_sel;
    logic [1:0] acc_op;
    logic       err_wr;
    logic       integ_wr;
    logic       out_wr;
    logic       jmp;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{mul_sel: MUL_LEAK, acc_op: ACC_HOLD, err_wr: 1'b0,
                                 integ_wr: 1'b0, out_wr: 1'b0, jmp: JMP_NEXT};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] tgt_max;
    logic signed [SAMPLE_W-1:0] tgt_min;
    logic        [BAND_W-1:0]   max_error;
    logic        [BAND_W-1:0]   dead_band;
    logic        [LIMIT_W-1:0]  integral_limit;
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic signed [SAMPLE_W-1:0] out_max;
    logic signed [SAMPLE_W-1:0] out_min;
  } cfg_t;

  // control program, one word per step
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = CTRL_NOP;
    case (step)
      3'd0: begin
        c.err_wr  = 1'b1;
        c.mul_sel = MUL_LEAK;
      end
      3'd1: begin
        c.integ_wr = 1'b1;
        c.mul_sel  = MUL_KP;
      end
      3'd2: begin
        c.mul_sel = MUL_KD;
        c.acc_op  = ACC_LOAD;
      end
      3'd3: begin
        c.mul_sel = MUL_KI;
        c.acc_op  = ACC_ADD;
      end
      3'd4: begin
        c.acc_op = ACC_SHADD;
      end
      3'd5: begin
        c.out_wr = 1'b1;
        c.jmp    = JMP_END;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/pidl_datapath.sv]
// datapath of the pid controller: error stage, leaky integrator, shared multiplier,
// accumulator and output clamp; driven by control words from pidl_pkg::ucode
`default_nettype none

module pidl_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire pidl_pkg::ctrl_t                      ctrl,
  input  wire logic                                 load,
  input  wire logic                                 action,
  input  wire logic signed [pidl_pkg::SAMPLE_W-1:0] setpoint,
  input  wire logic signed [pidl_pkg::SAMPLE_W-1:0] measured,
  input  wire logic signed [pidl_pkg::SAMPLE_W-1:0] external_rate,
  input  wire pidl_pkg::cfg_t                       cfg,
  output logic signed [pidl_pkg::SAMPLE_W-1:0]      drive
);

  localparam int SW = pidl_pkg::SAMPLE_W;
  localparam int EW = pidl_pkg::ERR_W;
  localparam int IW = pidl_pkg::INTEG_W;
  localparam int IF = pidl_pkg::INTEG_FRAC;
  localparam int AW = pidl_pkg::ACC_W;
  localparam int QW = pidl_pkg::ACC_W - pidl_pkg::SUM_SHIFT;

  logic                       action_r;
  logic signed [SW-1:0]       setpoint_r;
  logic signed [SW-1:0]       measured_r;
  logic signed [SW-1:0]       rate_r;
  logic signed [SW-1:0]       err_r;
  logic signed [SW-1:0]       last_error_r;
  logic signed [EW-1:0]       diff_r;
  logic signed [IW-1:0]       integral_r;
  logic signed [pidl_pkg::PROD_W-1:0] prod_r;
  logic signed [AW-1:0]       acc_r;

  // error stage
  logic signed [SW-1:0] tgt_hi, tgt;
  logic signed [EW-1:0] raw, me_pos, me_neg, err_hi, err_cl;
  logic        [EW-1:0] mag;
  logic                 dead;
  logic signed [SW-1:0] err_nxt;

  always_comb begin
    tgt_hi  = (setpoint_r > cfg.tgt_max) ? cfg.tgt_max : setpoint_r;
    tgt     = (tgt_hi < cfg.tgt_min) ? cfg.tgt_min : tgt_hi;
    raw     = EW'(tgt) - EW'(measured_r);
    me_pos  = $signed({2'b00, cfg.max_error});
    me_neg  = -me_pos;
    err_hi  = (raw > me_pos) ? me_pos : raw;
    err_cl  = (err_hi < me_neg) ? me_neg : err_hi;
    mag     = raw[EW-1] ? $unsigned(-raw) : $unsigned(raw);
    dead    = mag <= {2'b00, cfg.dead_band};
    err_nxt = dead ? '0 : err_cl[SW-1:0];
  end

  // leaky integrator, leak truncated toward zero
  logic signed [IW:0]   leak, err_sh, ilim_pos, ilim_neg, integ_sum, integ_hi, integ_lo;
  logic                 leak_up;
  logic signed [EW-1:0] diff_nxt;

  always_comb begin
    leak      = prod_r[pidl_pkg::LEAK_SHIFT +: IW + 1];
    leak_up   = prod_r[pidl_pkg::PROD_W-1] & (|prod_r[pidl_pkg::LEAK_SHIFT-1:0]);
    err_sh    = $signed({{(IW + 1 - SW - IF){err_r[SW-1]}}, err_r, {IF{1'b0}}});
    integ_sum = leak + err_sh + $signed({{IW{1'b0}}, leak_up});
    ilim_pos  = $signed({2'b00, cfg.integral_limit, {IF{1'b0}}});
    ilim_neg  = -ilim_pos;
    integ_hi  = (integ_sum > ilim_pos) ? ilim_pos : integ_sum;
    integ_lo  = (integ_hi < ilim_neg) ? ilim_neg : integ_hi;
    diff_nxt  = action_r ? EW'(rate_r) : (EW'(err_r) - EW'(last_error_r));
  end

  // shared multiplier
  logic signed [pidl_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pidl_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pidl_pkg::PROD_W-1:0]  mul_out;

  always_comb begin
    case (ctrl.mul_sel)
      pidl_pkg::MUL_KP: begin
        mul_a = pidl_pkg::MUL_A_W'(err_r);
        mul_b = pidl_pkg::MUL_B_W'(cfg.gain_p);
      end
      pidl_pkg::MUL_KD: begin
        mul_a = pidl_pkg::MUL_A_W'(diff_r);
        mul_b = pidl_pkg::MUL_B_W'(cfg.gain_d);
      end
      pidl_pkg::MUL_KI: begin
        mul_a = pidl_pkg::MUL_A_W'(integral_r);
        mul_b = pidl_pkg::MUL_B_W'(cfg.gain_i);
      end
      default: begin
        mul_a = pidl_pkg::MUL_A_W'(integral_r);
        mul_b = pidl_pkg::MUL_B_W'(pidl_pkg::LEAK_NUM);
      end
    endcase
    mul_out = mul_a * mul_b;
  end

  // accumulator
  logic signed [AW-1:0] acc_nxt;

  always_comb begin
    case (ctrl.acc_op)
      pidl_pkg::ACC_LOAD:  acc_nxt = prod_r[AW-1:0];
      pidl_pkg::ACC_ADD:   acc_nxt = acc_r + prod_r[AW-1:0];
      pidl_pkg::ACC_SHADD: acc_nxt = {acc_r[AW-1-IF:0], {IF{1'b0}}} + prod_r[AW-1:0];
      default:             acc_nxt = acc_r;
    endcase
  end

  // output truncation toward zero and clamp
  logic                 drv_up;
  logic signed [QW-1:0] drv_q, omax, omin, drv_hi, drv_lo;

  always_comb begin
    drv_up = acc_r[AW-1] & (|acc_r[pidl_pkg::SUM_SHIFT-1:0]);
    drv_q  = $signed(acc_r[AW-1:pidl_pkg::SUM_SHIFT] + QW'(drv_up));
    omax   = QW'(cfg.out_max);
    omin   = QW'(cfg.out_min);
    drv_hi = (drv_q > omax) ? omax : drv_q;
    drv_lo = (drv_hi < omin) ? omin : drv_hi;
    drive  = drv_lo[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action_r   <= action;
      setpoint_r <= setpoint;
      measured_r <= measured;
      rate_r     <= external_rate;
    end
    if (ctrl.err_wr) begin
      err_r <= err_nxt;
    end
    if (ctrl.integ_wr) begin
      diff_r <= diff_nxt;
    end
    prod_r <= mul_out;
    acc_r  <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      integral_r   <= '0;
    end else if (ctrl.integ_wr) begin
      last_error_r <= err_r;
      integral_r   <= integ_lo[IW-1:0];
    end
  end

endmodule

`default_nettype wire

[sv/pid_leaky_integrator_controller.sv]
// each item runs through six microcode steps on one shared 33x18 multiplier; the
// last step holds while a finished drive is still stalled
// a new item is taken in the cycle the previous one writes the output register
// reset (synchronous, rst_n low): sequencer idle, output empty, integrator and last
// error zero, registers to defaults; uses pidl_pkg and pidl_datapath
`default_nettype none

module pid_leaky_integrator_controller (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_action,
  input  wire logic signed [pidl_pkg::SAMPLE_W-1:0] in_setpoint,
  input  wire logic signed [pidl_pkg::SAMPLE_W-1:0] in_measured,
  input  wire logic signed [pidl_pkg::SAMPLE_W-1:0] in_external_rate,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [pidl_pkg::SAMPLE_W-1:0]      out_drive,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pidl_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [pidl_pkg::CFG_W-1:0]           pwdata,
  output logic [pidl_pkg::CFG_W-1:0]                prdata,
  output logic                                      pready
);

  localparam logic [31:0] LIMITS_RST = 32'h7FFF_8000;

  // configuration registers
  logic [pidl_pkg::CFG_W-1:0]    tgt_lim_r;
  logic [pidl_pkg::BAND_W-1:0]   max_error_r;
  logic [pidl_pkg::BAND_W-1:0]   dead_band_r;
  logic [pidl_pkg::LIMIT_W-1:0]  integ_limit_r;
  logic [pidl_pkg::GAIN_W-1:0]   gain_p_r;
  logic [pidl_pkg::GAIN_W-1:0]   gain_i_r;
  logic [pidl_pkg::GAIN_W-1:0]   gain_d_r;
  logic [pidl_pkg::CFG_W-1:0]    out_lim_r;

  logic                             cfg_wr;
  logic [pidl_pkg::CFG_IDX_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[pidl_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_lim_r     <= LIMITS_RST;
      max_error_r   <= '1;
      dead_band_r   <= '0;
      integ_limit_r <= '1;
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      out_lim_r     <= LIMITS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pidl_pkg::REG_TARGET_LIMITS:  tgt_lim_r     <= pwdata;
        pidl_pkg::REG_MAX_ERROR:      max_error_r   <= pwdata[pidl_pkg::BAND_W-1:0];
        pidl_pkg::REG_DEAD_BAND:      dead_band_r   <= pwdata[pidl_pkg::BAND_W-1:0];
        pidl_pkg::REG_INTEGRAL_LIMIT: integ_limit_r <= pwdata[pidl_pkg::LIMIT_W-1:0];
        pidl_pkg::REG_GAIN_P:         gain_p_r      <= pwdata[pidl_pkg::GAIN_W-1:0];
        pidl_pkg::REG_GAIN_I:         gain_i_r      <= pwdata[pidl_pkg::GAIN_W-1:0];
        pidl_pkg::REG_GAIN_D:         gain_d_r      <= pwdata[pidl_pkg::GAIN_W-1:0];
        pidl_pkg::REG_OUTPUT_LIMITS:  out_lim_r     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pidl_pkg::REG_TARGET_LIMITS:  prdata = tgt_lim_r;
      pidl_pkg::REG_MAX_ERROR:      prdata = pidl_pkg::CFG_W'(max_error_r);
      pidl_pkg::REG_DEAD_BAND:      prdata = pidl_pkg::CFG_W'(dead_band_r);
      pidl_pkg::REG_INTEGRAL_LIMIT: prdata = pidl_pkg::CFG_W'(integ_limit_r);
      pidl_pkg::REG_GAIN_P:         prdata = pidl_pkg::CFG_W'(gain_p_r);
      pidl_pkg::REG_GAIN_I:         prdata = pidl_pkg::CFG_W'(gain_i_r);
      pidl_pkg::REG_GAIN_D:         prdata = pidl_pkg::CFG_W'(gain_d_r);
      pidl_pkg::REG_OUTPUT_LIMITS:  prdata = out_lim_r;
      default:                      prdata = '0;
    endcase
  end

  pidl_pkg::cfg_t cfg;

  always_comb begin
    cfg.tgt_max        = tgt_lim_r[31:16];
    cfg.tgt_min        = tgt_lim_r[15:0];
    cfg.max_error      = max_error_r;
    cfg.dead_band      = dead_band_r;
    cfg.integral_limit = integ_limit_r;
    cfg.gain_p         = gain_p_r;
    cfg.gain_i         = gain_i_r;
    cfg.gain_d         = gain_d_r;
    cfg.out_max        = out_lim_r[31:16];
    cfg.out_min        = out_lim_r[15:0];
  end

  // microcode sequencer
  logic                          busy_r, busy_nxt;
  logic [pidl_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [pidl_pkg::SAMPLE_W-1:0] out_drive_r;
  pidl_pkg::ctrl_t               ctrl_rom, ctrl_eff;
  logic                          out_free, go, finish, in_acc;
  logic signed [pidl_pkg::SAMPLE_W-1:0] drive_val;

  always_comb begin
    ctrl_rom = pidl_pkg::ucode(step_r);
    out_free = !out_valid_r || !out_stall;
    go       = (ctrl_rom.jmp == pidl_pkg::JMP_NEXT) || out_free;
    ctrl_eff = (busy_r && go) ? ctrl_rom : pidl_pkg::CTRL_NOP;
    finish   = busy_r && go && (ctrl_rom.jmp == pidl_pkg::JMP_END);
    in_stall = busy_r && !finish;
    in_acc   = in_valid && !in_stall;

    busy_nxt = busy_r;
    step_nxt = step_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (busy_r && go) begin
      step_nxt = step_r + pidl_pkg::STEP_W'(1);
    end

    out_valid_nxt = out_valid_r;
    if (ctrl_eff.out_wr) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_eff.out_wr) begin
      out_drive_r <= drive_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  pidl_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl_eff),
    .load          (in_acc),
    .action        (in_action),
    .setpoint      (in_setpoint),
    .measured      (in_measured),
    .external_rate (in_external_rate),
    .cfg           (cfg),
    .drive         (drive_val)
  );

  // an accepted beat restarts the program at its first step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r && (step_r == '0))
    else $error("sequencer did not start at step zero");

  // the step counter never runs past the program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= pidl_pkg::LAST_STEP))
    else $error("step counter out of range");

  // finishing an item always leaves a result in the output register
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("item finished without a result");

  // a result only appears as the work of an item ends
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(finish))
    else $error("result appeared without a finished item");

endmodule

`default_nettype wire
